/* sv/fse_pkg.sv */
`timescale 1ns / 1ps
package fse_pkg;

	localparam int STRING_MAX  = 48;
	localparam int LEN_W       = $clog2(STRING_MAX + 1);
	localparam int ADDR_W      = $clog2(STRING_MAX);
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int LABEL_W     = 17;
	localparam int NUM_DIGITS  = 6;
	localparam int BCD_W       = 4 * NUM_DIGITS;
	localparam int NCNT_W      = $clog2(LABEL_W + 1);

	localparam logic [6:0] LAST_COL = 7'd71;
	localparam logic [3:0] MAX_CONT = 4'd8;

	localparam logic [1:0] CMD_CHAR = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd1;
	localparam logic [1:0] CMD_CONT = 2'd2;
	localparam logic [1:0] CMD_GOTO = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NOT   = 8'h21;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_OR    = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;

	typedef enum logic [2:0] {
		OP_NONE, OP_GT, OP_LT, OP_EQ, OP_NOT, OP_AND, OP_OR
	} op_t;

	typedef enum logic [3:0] {
		TXT_GT, TXT_GE, TXT_LT, TXT_LE, TXT_NE, TXT_EQ, TXT_EQSIGN,
		TXT_NOT, TXT_AND, TXT_OR, TXT_CONTINUE, TXT_GOTO
	} txt_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         ch;
		logic               last_in_chunk;
		logic [LABEL_W-1:0] label;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       card_end;
		logic       string_overflow;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       put_req;
		logic [7:0] put_char;
		logic       from_ram;
		logic       card_end_req;
		logic       finish_req;
		logic       num_start;
		logic       num_sel_len;
		logic       num_shift;
		logic       str_wr;
		logic [7:0] str_data;
		logic       str_clear;
		logic       rd_clr;
		logic       rd_inc;
		logic       ovf;
	} dp_cmd_t;

	typedef struct packed {
		logic       put_done;
		logic       emit_ok;
		logic       num_busy;
		logic [3:0] digit;
		logic       col_lt7;
		logic       mod3_one;
		logic       label_nz;
		logic       str_full;
		logic       str_empty;
		logic       rd_last;
	} dp_sts_t;

	typedef struct packed {
		txt_t txt;
		logic paired;
	} settle_t;

	function automatic logic [63:0] text_word(txt_t id);
		case (id)
			TXT_GT:       return {".gt.", 32'h0};
			TXT_GE:       return {".ge.", 32'h0};
			TXT_LT:       return {".lt.", 32'h0};
			TXT_LE:       return {".le.", 32'h0};
			TXT_NE:       return {".ne.", 32'h0};
			TXT_EQ:       return {".eq.", 32'h0};
			TXT_EQSIGN:   return {"=", 56'h0};
			TXT_NOT:      return {".not.", 24'h0};
			TXT_AND:      return {".and.", 24'h0};
			TXT_OR:       return {".or.", 32'h0};
			TXT_CONTINUE: return "continue";
			TXT_GOTO:     return {"goto ", 24'h0};
			default:      return 64'h0;
		endcase
	endfunction

	function automatic logic [3:0] text_len(txt_t id);
		case (id)
			TXT_EQSIGN:                 return 4'd1;
			TXT_NOT, TXT_AND, TXT_GOTO: return 4'd5;
			TXT_CONTINUE:               return 4'd8;
			default:                    return 4'd4;
		endcase
	endfunction

	function automatic logic [7:0] text_char(txt_t id, logic [2:0] idx);
		logic [63:0] w;
		w = text_word(id);
		return w[{3'd7 - idx, 3'b000} +: 8];
	endfunction

	// Resolve a waiting operator against the next character, if any.
	function automatic settle_t settle_sel(op_t p, logic have, logic [7:0] nx);
		settle_t r;
		logic eq;
		eq = have && (nx == CH_EQ);
		r.paired = 1'b0;
		r.txt = TXT_GT;
		case (p)
			OP_GT: begin
				r.txt = eq ? TXT_GE : TXT_GT;
				r.paired = eq;
			end
			OP_LT: begin
				if (eq) begin
					r.txt = TXT_LE;
					r.paired = 1'b1;
				end else if (have && nx == CH_GT) begin
					r.txt = TXT_NE;
					r.paired = 1'b1;
				end else begin
					r.txt = TXT_LT;
				end
			end
			OP_EQ: begin
				r.txt = eq ? TXT_EQ : TXT_EQSIGN;
				r.paired = eq;
			end
			OP_NOT: begin
				r.txt = eq ? TXT_NE : TXT_NOT;
				r.paired = eq;
			end
			OP_AND: begin
				r.txt = TXT_AND;
				r.paired = have && nx == CH_AND;
			end
			OP_OR: begin
				r.txt = TXT_OR;
				r.paired = have && nx == CH_OR;
			end
			default: begin
				r.txt = TXT_GT;
				r.paired = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

/* sv/fse_ram.sv */
`timescale 1ns / 1ps
module fse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

/* sv/fse_datapath.sv */
`timescale 1ns / 1ps
module fse_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fse_pkg::dp_cmd_t                cmd,
	output fse_pkg::dp_sts_t                sts,
	input  logic [fse_pkg::LABEL_W-1:0]     label,
	input  logic                            cfg_we,
	input  logic [3:0]                      cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fse_pkg::out_item_t              out_item
);
	import fse_pkg::*;

	logic [3:0]         cfg_q;
	logic [3:0]         cc;
	logic [6:0]         col_q;
	logic [1:0]         m3_q;
	logic               pad_q;
	logic [LABEL_W-1:0] label_q;
	logic [LEN_W-1:0]   len_q;
	logic [ADDR_W-1:0]  rd_idx_q;
	logic [7:0]         rd_data;
	logic [LABEL_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic [NCNT_W-1:0]  ncnt_q;
	logic [CNT_W-1:0]   cnt_q;
	out_item_t          h_q;
	logic               h_vld_q;
	out_item_t          o_q;
	logic               o_vld_q;

	logic       o_free;
	logic       emit;
	logic [7:0] em_char;
	logic       em_end;
	logic       col_inc;
	logic       col_zero;
	logic       pad_set;
	logic       pad_clr;
	logic       put_done;
	logic [7:0] put_data;
	out_item_t  em_item;

	assign cc       = (cfg_q > MAX_CONT) ? MAX_CONT : cfg_q;
	assign o_free   = !o_vld_q || !out_stall;
	assign put_data = cmd.from_ram ? rd_data : cmd.put_char;

	fse_ram #(.WIDTH(8), .DEPTH(STRING_MAX)) u_buf (
		.clk     (clk),
		.we      (cmd.str_wr),
		.wr_addr (len_q[ADDR_W-1:0]),
		.wr_data (cmd.str_data),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// Card writer: continuation break, padding and mark ahead of the character, or a card end on request.
	always_comb begin
		emit     = 1'b0;
		em_char  = CH_NUL;
		em_end   = 1'b0;
		col_inc  = 1'b0;
		col_zero = 1'b0;
		pad_set  = 1'b0;
		pad_clr  = 1'b0;
		put_done = 1'b0;
		if (cmd.put_req && o_free) begin
			emit = 1'b1;
			if (pad_q) begin
				col_inc = 1'b1;
				if ({1'b0, col_q} + 8'd1 < {4'd0, cc}) begin
					em_char = CH_SPACE;
				end else begin
					em_char = CH_AMP;
					pad_clr = 1'b1;
				end
			end else if (col_q > LAST_COL) begin
				em_end   = 1'b1;
				col_zero = 1'b1;
				pad_set  = 1'b1;
			end else begin
				em_char  = put_data;
				col_inc  = 1'b1;
				put_done = 1'b1;
			end
		end else if (cmd.card_end_req && o_free) begin
			emit     = 1'b1;
			em_end   = 1'b1;
			col_zero = 1'b1;
		end
		em_item.out_char        = em_end ? CH_NUL : em_char;
		em_item.card_end        = em_end;
		em_item.string_overflow = cmd.ovf;
		em_item.last            = 1'b0;
	end

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			col_q    <= '0;
			m3_q     <= '0;
			pad_q    <= 1'b0;
			label_q  <= '0;
			len_q    <= '0;
			rd_idx_q <= '0;
			bin_q    <= '0;
			bcd_q    <= '0;
			ncnt_q   <= '0;
			cnt_q    <= '0;
			h_q      <= '0;
			h_vld_q  <= 1'b0;
			o_q      <= '0;
			o_vld_q  <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q <= cfg_data;
			if (cmd.load)
				label_q <= label;

			if (col_zero) begin
				col_q <= '0;
				m3_q  <= '0;
			end else if (col_inc) begin
				col_q <= col_q + 7'd1;
				m3_q  <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
			end
			if (pad_set)
				pad_q <= 1'b1;
			else if (pad_clr)
				pad_q <= 1'b0;

			if (cmd.str_clear)
				len_q <= '0;
			else if (cmd.str_wr)
				len_q <= len_q + 1'b1;
			if (cmd.rd_clr)
				rd_idx_q <= '0;
			else if (cmd.rd_inc)
				rd_idx_q <= rd_idx_q + 1'b1;

			// Binary to decimal, one bit per cycle, then one digit per shift.
			if (cmd.num_start) begin
				bin_q  <= cmd.num_sel_len ? LABEL_W'(len_q) : label_q;
				bcd_q  <= '0;
				ncnt_q <= NCNT_W'(LABEL_W);
			end else if (ncnt_q != '0) begin
				bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[LABEL_W-1]};
				bin_q  <= {bin_q[LABEL_W-2:0], 1'b0};
				ncnt_q <= ncnt_q - 1'b1;
			end else if (cmd.num_shift) begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end

			// One result held back so the final one can carry last.
			if (emit && cnt_q < CNT_W'(MAX_RESULTS)) begin
				if (h_vld_q) begin
					o_q     <= h_q;
					o_vld_q <= 1'b1;
				end else if (!out_stall) begin
					o_vld_q <= 1'b0;
				end
				h_q     <= em_item;
				h_vld_q <= 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end else if (cmd.finish_req && o_free) begin
				if (h_vld_q) begin
					o_q      <= h_q;
					o_q.last <= 1'b1;
					o_vld_q  <= 1'b1;
				end else if (!out_stall) begin
					o_vld_q <= 1'b0;
				end
				h_vld_q <= 1'b0;
				cnt_q   <= '0;
			end else if (o_vld_q && !out_stall) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = o_vld_q;
	assign out_item  = o_q;

	assign sts.put_done  = put_done;
	assign sts.emit_ok   = o_free;
	assign sts.num_busy  = (ncnt_q != '0);
	assign sts.digit     = bcd_q[BCD_W-1 -: 4];
	assign sts.col_lt7   = (col_q < 7'd7);
	assign sts.mod3_one  = (m3_q == 2'd1);
	assign sts.label_nz  = (label_q != '0);
	assign sts.str_full  = (len_q == LEN_W'(STRING_MAX));
	assign sts.str_empty = (len_q == '0);
	assign sts.rd_last   = (LEN_W'(rd_idx_q) + LEN_W'(1) == len_q);
endmodule

/* sv/fse_ctrl.sv */
`timescale 1ns / 1ps
module fse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  fse_pkg::in_item_t    in_item,
	output logic                 in_stall,
	output fse_pkg::dp_cmd_t     cmd,
	input  fse_pkg::dp_sts_t     sts
);
	import fse_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_CHAR, S_LASTC, S_LFLUSH, S_PUT, S_TEXT,
		S_TAB1, S_TAB2, S_TAB3, S_NUM_WAIT, S_NUM_SKIP, S_NUM_PUT,
		S_FL_START, S_FL_H, S_STR_ADDR, S_STR_PUT, S_STR_END,
		S_CMD, S_CMD_BODY, S_C2_TAB, S_C2_TXT, S_C3_TXT, S_C3_NUM,
		S_CEND, S_FINISH
	} state_t;

	state_t     state_q;
	state_t     ret_q;
	state_t     put_ret_q;
	logic [1:0] cmd_q;
	logic [7:0] ch_q;
	logic       lastc_q;
	logic       ovf_q;
	op_t        pend_q;
	logic       in_str_q;
	logic       delim_q;
	logic       trunc_q;
	txt_t       txt_q;
	logic [2:0] tidx_q;
	logic [2:0] dig_q;
	logic [7:0] put_char_q;

	logic [7:0] delim_ch;
	logic       is_delim;
	logic       item_trunc;
	logic       will_flush;
	logic       text_end;
	settle_t    st_ch;
	settle_t    st_none;

	assign delim_ch   = delim_q ? CH_SQ : CH_DQ;
	assign is_delim   = (in_item.ch == delim_ch);
	assign item_trunc = trunc_q ||
		(sts.str_full && in_item.ch != CH_NUL && !is_delim);
	assign will_flush = in_str_q && in_item.cmd == CMD_CHAR &&
		(is_delim || in_item.last_in_chunk);
	assign text_end   = ({1'b0, tidx_q} + 4'd1 == text_len(txt_q));
	assign st_ch      = settle_sel(pend_q, 1'b1, ch_q);
	assign st_none    = settle_sel(pend_q, 1'b0, CH_NUL);
	assign in_stall   = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.ovf      = ovf_q;
		cmd.str_data = ch_q;
		unique case (state_q)
			S_DISPATCH: begin
				if (cmd_q == CMD_CHAR && ch_q != CH_NUL && in_str_q &&
						ch_q != delim_ch && !sts.str_full)
					cmd.str_wr = 1'b1;
			end
			S_CHAR: begin
				if (ch_q == CH_DQ || ch_q == CH_SQ)
					cmd.str_clear = 1'b1;
			end
			S_PUT: begin
				cmd.put_req  = 1'b1;
				cmd.put_char = put_char_q;
			end
			S_TEXT: begin
				cmd.put_req  = 1'b1;
				cmd.put_char = text_char(txt_q, tidx_q);
			end
			S_NUM_SKIP: begin
				if (dig_q > 3'd1 && sts.digit == 4'd0)
					cmd.num_shift = 1'b1;
			end
			S_NUM_PUT: begin
				cmd.put_req   = 1'b1;
				cmd.put_char  = CH_ZERO | {4'd0, sts.digit};
				cmd.num_shift = sts.put_done;
			end
			S_FL_START: begin
				cmd.num_start   = 1'b1;
				cmd.num_sel_len = 1'b1;
				cmd.rd_clr      = 1'b1;
			end
			S_FL_H: begin
				cmd.put_req  = 1'b1;
				cmd.put_char = CH_H;
			end
			S_STR_PUT: begin
				cmd.put_req  = 1'b1;
				cmd.from_ram = 1'b1;
				cmd.rd_inc   = sts.put_done && !sts.rd_last;
			end
			S_STR_END: cmd.str_clear = 1'b1;
			S_CMD_BODY: begin
				cmd.str_clear = 1'b1;
				cmd.num_start = (cmd_q == CMD_CONT) && sts.label_nz;
			end
			S_C3_NUM:   cmd.num_start    = 1'b1;
			S_CEND:     cmd.card_end_req = 1'b1;
			S_FINISH:   cmd.finish_req   = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			put_ret_q  <= S_IDLE;
			cmd_q      <= CMD_CHAR;
			ch_q       <= '0;
			lastc_q    <= 1'b0;
			ovf_q      <= 1'b0;
			pend_q     <= OP_NONE;
			in_str_q   <= 1'b0;
			delim_q    <= 1'b0;
			trunc_q    <= 1'b0;
			txt_q      <= TXT_GT;
			tidx_q     <= '0;
			dig_q      <= '0;
			put_char_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= in_item.cmd;
						ch_q    <= in_item.ch;
						lastc_q <= in_item.last_in_chunk;
						ovf_q   <= will_flush && item_trunc;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (cmd_q != CMD_CHAR) begin
						state_q <= S_CMD;
					end else if (ch_q == CH_NUL) begin
						state_q <= S_LASTC;
					end else if (in_str_q) begin
						if (ch_q == delim_ch) begin
							state_q <= S_FL_START;
						end else begin
							if (sts.str_full)
								trunc_q <= 1'b1;
							state_q <= S_LASTC;
						end
					end else if (pend_q != OP_NONE) begin
						txt_q   <= st_ch.txt;
						tidx_q  <= '0;
						pend_q  <= OP_NONE;
						ret_q   <= st_ch.paired ? S_LASTC : S_CHAR;
						state_q <= S_TEXT;
					end else begin
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					state_q <= S_LASTC;
					case (ch_q)
						CH_DQ, CH_SQ: begin
							in_str_q <= 1'b1;
							delim_q  <= (ch_q == CH_SQ);
							trunc_q  <= 1'b0;
						end
						CH_GT:  pend_q <= OP_GT;
						CH_LT:  pend_q <= OP_LT;
						CH_EQ:  pend_q <= OP_EQ;
						CH_NOT: pend_q <= OP_NOT;
						CH_AND: pend_q <= OP_AND;
						CH_OR:  pend_q <= OP_OR;
						CH_TAB: begin
							ret_q   <= S_LASTC;
							state_q <= S_TAB1;
						end
						CH_NL: begin
							put_char_q <= CH_SPACE;
							put_ret_q  <= S_LASTC;
							state_q    <= S_PUT;
						end
						default: begin
							put_char_q <= ch_q;
							put_ret_q  <= S_LASTC;
							state_q    <= S_PUT;
						end
					endcase
				end
				S_LASTC: begin
					if (!lastc_q) begin
						state_q <= S_FINISH;
					end else if (pend_q != OP_NONE) begin
						txt_q   <= st_none.txt;
						tidx_q  <= '0;
						pend_q  <= OP_NONE;
						ret_q   <= S_LFLUSH;
						state_q <= S_TEXT;
					end else begin
						state_q <= S_LFLUSH;
					end
				end
				S_LFLUSH: state_q <= in_str_q ? S_FL_START : S_FINISH;
				S_PUT: begin
					if (sts.put_done)
						state_q <= put_ret_q;
				end
				S_TEXT: begin
					if (sts.put_done) begin
						if (text_end)
							state_q <= ret_q;
						else
							tidx_q <= tidx_q + 3'd1;
					end
				end
				S_TAB1: begin
					put_char_q <= CH_SPACE;
					put_ret_q  <= S_TAB2;
					state_q    <= S_PUT;
				end
				S_TAB2: begin
					if (sts.col_lt7) begin
						put_ret_q <= S_TAB2;
						state_q   <= S_PUT;
					end else begin
						state_q <= S_TAB3;
					end
				end
				S_TAB3: begin
					if (!sts.mod3_one) begin
						put_ret_q <= S_TAB3;
						state_q   <= S_PUT;
					end else begin
						state_q <= ret_q;
					end
				end
				S_NUM_WAIT: begin
					if (!sts.num_busy) begin
						dig_q   <= 3'(NUM_DIGITS);
						state_q <= S_NUM_SKIP;
					end
				end
				S_NUM_SKIP: begin
					if (dig_q > 3'd1 && sts.digit == 4'd0)
						dig_q <= dig_q - 3'd1;
					else
						state_q <= S_NUM_PUT;
				end
				S_NUM_PUT: begin
					if (sts.put_done) begin
						dig_q <= dig_q - 3'd1;
						if (dig_q == 3'd1)
							state_q <= ret_q;
					end
				end
				S_FL_START: begin
					ret_q   <= S_FL_H;
					state_q <= S_NUM_WAIT;
				end
				S_FL_H: begin
					if (sts.put_done)
						state_q <= sts.str_empty ? S_STR_END : S_STR_ADDR;
				end
				S_STR_ADDR: state_q <= S_STR_PUT;
				S_STR_PUT: begin
					if (sts.put_done)
						state_q <= sts.rd_last ? S_STR_END : S_STR_ADDR;
				end
				S_STR_END: begin
					in_str_q <= 1'b0;
					trunc_q  <= 1'b0;
					state_q  <= S_FINISH;
				end
				S_CMD: begin
					if (pend_q != OP_NONE) begin
						txt_q   <= st_none.txt;
						tidx_q  <= '0;
						pend_q  <= OP_NONE;
						ret_q   <= S_CMD_BODY;
						state_q <= S_TEXT;
					end else begin
						state_q <= S_CMD_BODY;
					end
				end
				S_CMD_BODY: begin
					in_str_q <= 1'b0;
					trunc_q  <= 1'b0;
					unique case (cmd_q)
						CMD_CONT: begin
							if (sts.label_nz) begin
								ret_q   <= S_C2_TAB;
								state_q <= S_NUM_WAIT;
							end else begin
								state_q <= S_C2_TAB;
							end
						end
						CMD_GOTO: begin
							ret_q   <= S_C3_TXT;
							state_q <= S_TAB1;
						end
						default: state_q <= S_CEND;
					endcase
				end
				S_C2_TAB: begin
					ret_q   <= S_C2_TXT;
					state_q <= S_TAB1;
				end
				S_C2_TXT: begin
					txt_q   <= TXT_CONTINUE;
					tidx_q  <= '0;
					ret_q   <= S_CEND;
					state_q <= S_TEXT;
				end
				S_C3_TXT: begin
					txt_q   <= TXT_GOTO;
					tidx_q  <= '0;
					ret_q   <= S_C3_NUM;
					state_q <= S_TEXT;
				end
				S_C3_NUM: begin
					ret_q   <= S_CEND;
					state_q <= S_NUM_WAIT;
				end
				S_CEND: begin
					if (sts.emit_ok)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.emit_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/fortran_statement_emitter_top.sv */
`timescale 1ns / 1ps
// Sequence: an item is taken while the sequencer is idle, then dispatched, and each card character
//   is one put; each tab padding space is a put then a column check, a number is converted bit
//   by bit and its leading zeros skipped, and a buffered string character is an address then a put.
// Throughput: one item at a time; a result waits in a holding register until the next one or
//   the item end, and the next item is taken the cycle after the final result is registered.
// Reset: arst_n clears column, lexical state, string length and the output stage at once.
module fortran_statement_emitter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fse_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output fse_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data
);
	import fse_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;
	logic    accept;

	// Take an item only while the sequencer is parked.
	assign accept = in_valid && !in_stall;

	// Sequencer: operator lookahead, string state, and the order of card text.
	fse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_item  (in_item),
		.in_stall (in_stall),
		.cmd      (dp_cmd),
		.sts      (dp_sts)
	);

	// Card writer, decimal converter, string buffer and output stage.
	fse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.label     (in_item.label),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule
